>>> src/otp_pkg.sv
// ----------------------------------------------------------------------------
// otp_pkg: shared types and codes for the one-shot timer pool
// Operation and result codes, stream payload widths and the cell control word.
// ----------------------------------------------------------------------------
package otp_pkg;

   localparam int OP_W          = 2;
   localparam int KIND_W        = 2;
   localparam int SLOT_FIELD_W  = 3;
   localparam int TAG_W         = 32;
   localparam int DELAY_W       = 32;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = 40;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STARTED  = 2'd0,
      KIND_NO_FREE  = 2'd1,
      KIND_EXP_CALL = 2'd2,
      KIND_EXP_MSG  = 2'd3
   } kind_type;

   // per-cell control: rotate the ring, load a new timer, or drop one
   typedef struct packed {
      logic shift;
      logic load;
      logic kill;
   } cell_ctl_type;

endpackage

>>> src/one_shot_timer_pool_top.sv
// ----------------------------------------------------------------------------
// one_shot_timer_pool_top: pool of one-shot countdown timers
// Ring of timer cells rotating past a single decrement unit.
// ----------------------------------------------------------------------------
// One word is taken at a time. A stop clears its slot at once; a start loads
// the slot at once and its report passes through the pending register to the
// output register. A tick rotates the ring of SLOTS cells one position per
// cycle past the one decrement unit, unless the result side stalls it, then
// the flush state sends the held-back result; after the last step every
// cell is back at its home position. Expiries leave in ascending slot order,
// the last one of a tick marked with tlast.
module one_shot_timer_pool_top import otp_pkg::*; #(
   parameter int SLOTS      = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] delay_ticks, [32] deliver_as_message, [64:33] handler_tag,
   // [67:65] stop_slot, [71:68] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] slot, [34:3] tag, [39:35] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] kind
   output logic [KIND_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;

   // pending result: held back until we know whether it is the last one
   logic                    pend_valid_ff, pend_valid_in;
   kind_type                pend_kind_ff, pend_kind_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0]        pend_tag_ff, pend_tag_in;

   logic                    out_valid_ff, out_valid_in;
   kind_type                out_kind_ff, out_kind_in;
   logic [SLOT_FIELD_W-1:0] out_slot_ff, out_slot_in;
   logic [TAG_W-1:0]        out_tag_ff, out_tag_in;
   logic                    out_last_ff, out_last_in;

   logic                  cell_active [SLOTS];
   logic                  cell_mode   [SLOTS];
   logic [COUNT_BITS-1:0] cell_count  [SLOTS];
   logic [TAG_W-1:0]      cell_tag    [SLOTS];
   cell_ctl_type          cell_ctl    [SLOTS];

   logic                  head_active;
   logic [COUNT_BITS-1:0] head_count;
   logic                  head_exp;
   kind_type              head_kind;

   op_type                req_op;
   logic [DELAY_W-1:0]    req_delay;
   logic                  req_msg;
   logic [TAG_W-1:0]      req_tag;
   logic [SLOT_FIELD_W-1:0] req_stop;
   logic                  req_fire;
   logic                  free_any;
   logic [IDX_W-1:0]      free_idx;
   logic                  out_free;
   logic                  step_go;

   assign req_op    = op_type'(req_tuser);
   assign req_delay = req_tdata[31:0];
   assign req_msg   = req_tdata[32];
   assign req_tag   = req_tdata[64:33];
   assign req_stop  = req_tdata[67:65];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!cell_active[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // an expiry with an older result still pending needs room downstream
   assign step_go = (state_ff == ST_SWEEP) && !(head_exp && pend_valid_ff && !out_free);

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic                  nbr_active;
      logic                  nbr_mode;
      logic [COUNT_BITS-1:0] nbr_count;
      logic [TAG_W-1:0]      nbr_tag;

      if (i == SLOTS - 1) begin : g_tail
         assign nbr_active = head_active;
         assign nbr_mode   = cell_mode[0];
         assign nbr_count  = head_count;
         assign nbr_tag    = cell_tag[0];
      end else begin : g_mid
         assign nbr_active = cell_active[i+1];
         assign nbr_mode   = cell_mode[i+1];
         assign nbr_count  = cell_count[i+1];
         assign nbr_tag    = cell_tag[i+1];
      end

      always_comb begin
         cell_ctl[i].shift = step_go;
         cell_ctl[i].load  = req_fire && (req_op == OP_START) && free_any &&
                             (free_idx == IDX_W'(i));
         cell_ctl[i].kill  = req_fire && (req_op == OP_STOP) &&
                             (32'(i) == 32'(req_stop));
      end

      otp_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .nbr_active (nbr_active),
         .nbr_mode   (nbr_mode),
         .nbr_count  (nbr_count),
         .nbr_tag    (nbr_tag),
         .ld_mode    (req_msg),
         .ld_count   (COUNT_BITS'(req_delay)),
         .ld_tag     (req_tag),
         .active     (cell_active[i]),
         .mode       (cell_mode[i]),
         .count      (cell_count[i]),
         .tag        (cell_tag[i])
      );
   end

   otp_tick #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tick (
      .active      (cell_active[0]),
      .mode        (cell_mode[0]),
      .count       (cell_count[0]),
      .next_active (head_active),
      .next_count  (head_count),
      .expired     (head_exp),
      .exp_kind    (head_kind)
   );

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_TICK: begin
                     state_in = ST_SWEEP;
                     step_in  = '0;
                  end
                  OP_START: begin
                     state_in      = ST_FLUSH;
                     pend_valid_in = 1'b1;
                     pend_kind_in  = free_any ? KIND_STARTED : KIND_NO_FREE;
                     pend_slot_in  = free_any ? SLOT_FIELD_W'(free_idx) : '0;
                     pend_tag_in   = '0;
                  end
                  OP_STOP, OP_UNUSED: begin
                     state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (step_go) begin
               if (head_exp) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = pend_kind_ff;
                     out_slot_in  = pend_slot_ff;
                     out_tag_in   = pend_tag_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = head_kind;
                  pend_slot_in  = SLOT_FIELD_W'(step_ff);
                  pend_tag_in   = cell_tag[0];
               end
               if (step_ff == IDX_W'(SLOTS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in = step_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = pend_kind_ff;
               out_slot_in   = pend_slot_ff;
               out_tag_in    = pend_tag_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - SLOT_FIELD_W - TAG_W){1'b0}}, out_tag_ff, out_slot_ff};

   logic [31:0] active_cnt;
   always_comb begin
      active_cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         active_cnt = active_cnt + 32'(cell_active[i]);
      end
   end

   // nothing may be left pending once the block takes a new word
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   // a stalled sweep must not advance the slot counter
   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && !step_go) |=> (step_ff == $past(step_ff)))
      else $error("sweep step moved while stalled");

   // a tick never activates a timer
   a_sweep_no_new: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> (active_cnt <= $past(active_cnt)))
      else $error("active count grew during a tick");

   // a start with room reports a started slot
   a_start_report: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_START) && free_any) |=>
         (pend_valid_ff && (pend_kind_ff == KIND_STARTED)))
      else $error("start did not report its slot");

   // a result marked non-final is only produced while a tick is sweeping
   a_nonlast_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (out_valid_in && !out_valid_ff && !out_last_in) |-> (state_ff == ST_SWEEP))
      else $error("non-final result outside a tick");

endmodule

>>> src/otp_cell.sv
// ----------------------------------------------------------------------------
// otp_cell: one timer slot in the rotating ring
// Holds active/mode/count/tag; takes its neighbor's contents on a shift.
// ----------------------------------------------------------------------------
module otp_cell import otp_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic                  nbr_active,
   input  logic                  nbr_mode,
   input  logic [COUNT_BITS-1:0] nbr_count,
   input  logic [TAG_W-1:0]      nbr_tag,
   input  logic                  ld_mode,
   input  logic [COUNT_BITS-1:0] ld_count,
   input  logic [TAG_W-1:0]      ld_tag,
   output logic                  active,
   output logic                  mode,
   output logic [COUNT_BITS-1:0] count,
   output logic [TAG_W-1:0]      tag
);

   logic                  active_ff, active_in;
   logic                  mode_ff, mode_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;

   always_comb begin
      active_in = active_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      tag_in    = tag_ff;
      priority if (ctl.shift) begin
         active_in = nbr_active;
         mode_in   = nbr_mode;
         count_in  = nbr_count;
         tag_in    = nbr_tag;
      end else if (ctl.load) begin
         active_in = 1'b1;
         mode_in   = ld_mode;
         count_in  = ld_count;
         tag_in    = ld_tag;
      end else if (ctl.kill) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mode_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      tag_ff   <= tag_in;
   end

   assign active = active_ff;
   assign mode   = mode_ff;
   assign count  = count_ff;
   assign tag    = tag_ff;

endmodule

>>> src/otp_tick.sv
// ----------------------------------------------------------------------------
// otp_tick: decrement unit at the head of the ring
// Counts the passing slot down by one and flags an expiry when it hits zero.
// ----------------------------------------------------------------------------
module otp_tick import otp_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  active,
   input  logic                  mode,
   input  logic [COUNT_BITS-1:0] count,
   output logic                  next_active,
   output logic [COUNT_BITS-1:0] next_count,
   output logic                  expired,
   output kind_type              exp_kind
);

   logic [COUNT_BITS-1:0] dec;

   // zero wraps to all ones, so a zero delay runs the full count range
   assign dec         = count - COUNT_BITS'(1);
   assign expired     = active && (dec == '0);
   assign next_active = active && !expired;
   assign next_count  = active ? dec : count;
   assign exp_kind    = mode ? KIND_EXP_MSG : KIND_EXP_CALL;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the one-shot timer pool
// Drives start, stop, tick and unused words in bursts, predicts every report
// and expiry from a behavioral copy of the pool, and checks each result word
// in order while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import otp_pkg::*;

   localparam int NSLOTS = 8;

   typedef struct packed {
      kind_type          kind;
      logic [2:0]        slot;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } report_type;

   typedef enum int {RX_FULL, RX_RANDOM, RX_PATTERN} rx_style_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [31:0] delay_ticks, [32] deliver_as_message, [64:33] handler_tag,
   // [67:65] stop_slot, [71:68] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [1:0] operation
   logic [OP_W-1:0]        req_tuser = OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [2:0] slot, [34:3] tag, [39:35] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] kind
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   // pool copy used for prediction
   logic [NSLOTS-1:0]  armed_mask = '0;
   logic [NSLOTS-1:0]  msg_mode = '0;
   logic [DELAY_W-1:0] count_left [NSLOTS];
   logic [TAG_W-1:0]   tag_store [NSLOTS];

   report_type   pending_reports [$];
   int           mismatch_count = 0;
   int           burst_left = 0;
   bit           sender_idle_on = 1'b1;
   rx_style_type rx_mode = RX_FULL;
   int           rx_hold_req = 0;
   int           hold_left = 0;
   int           rx_phase = 0;

   one_shot_timer_pool_top #(
      .SLOTS      (NSLOTS),
      .COUNT_BITS (DELAY_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Applies one accepted word to the pool copy and queues the words it causes.
   function automatic void advance_pool(op_type op, logic [DELAY_W-1:0] delay,
                                        logic as_msg, logic [TAG_W-1:0] tag,
                                        logic [2:0] stop_id);
      report_type rep;
      report_type prev;
      bit         have_prev;
      int         free_slot;
      have_prev = 1'b0;
      free_slot = -1;
      prev = '0;
      case (op)
         OP_START: begin
            for (int i = 0; i < NSLOTS; i++)
               if (!armed_mask[i] && free_slot < 0) free_slot = i;
            rep = '0;
            rep.last = 1'b1;
            if (free_slot < 0) begin
               rep.kind = KIND_NO_FREE;
            end else begin
               count_left[free_slot] = delay;
               tag_store[free_slot] = tag;
               msg_mode[free_slot] = as_msg;
               armed_mask[free_slot] = 1'b1;
               rep.kind = KIND_STARTED;
               rep.slot = 3'(free_slot);
            end
            pending_reports.push_back(rep);
         end
         OP_STOP: begin
            if (int'(stop_id) < NSLOTS) armed_mask[stop_id] = 1'b0;
         end
         OP_TICK: begin
            for (int i = 0; i < NSLOTS; i++) begin
               if (armed_mask[i]) begin
                  count_left[i] = count_left[i] - 1'b1;
                  if (count_left[i] == '0) begin
                     // hold back one word so the final one can carry last
                     if (have_prev) pending_reports.push_back(prev);
                     prev.kind = msg_mode[i] ? KIND_EXP_MSG : KIND_EXP_CALL;
                     prev.slot = 3'(i);
                     prev.tag  = tag_store[i];
                     prev.last = 1'b0;
                     have_prev = 1'b1;
                     armed_mask[i] = 1'b0;
                  end
               end
            end
            if (have_prev) begin
               prev.last = 1'b1;
               pending_reports.push_back(prev);
            end
         end
         default: ;
      endcase
   endfunction

   // results are checked before the same edge's input is applied
   always @(posedge clock) begin
      report_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected word: kind %0d slot %0d tag %h last %0b",
                      rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3], rsp_tlast);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[2:0] !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[2:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[34:3] !== want.tag) begin
                  $error("tag: expected %h, actual %h", want.tag, rsp_tdata[34:3]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_pool(op_type'(req_tuser), req_tdata[31:0], req_tdata[32],
                         req_tdata[64:33], req_tdata[67:65]);
      end
   end

   // result side: long hold-offs on request, otherwise the current stall style
   always @(posedge clock) begin
      if (rx_hold_req > 0) begin
         hold_left = rx_hold_req;
         rx_hold_req = 0;
      end
      rx_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_FULL: rsp_tready <= 1'b1;
            RX_RANDOM: begin
               if ($urandom_range(0, 99) < 3) hold_left = $urandom_range(8, 20);
               rsp_tready <= ($urandom_range(0, 99) < 65);
            end
            default: rsp_tready <= ((rx_phase % 7) < 4);
         endcase
      end
   end

   task automatic send_word(input op_type op, input logic [DELAY_W-1:0] delay,
                            input logic as_msg, input logic [TAG_W-1:0] tag,
                            input logic [2:0] stop_id);
      if (burst_left == 0) begin
         if (sender_idle_on) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, stop_id, tag, as_msg, delay};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic start_timer(input logic [DELAY_W-1:0] delay, input logic as_msg,
                              input logic [TAG_W-1:0] tag);
      send_word(OP_START, delay, as_msg, tag, 3'($urandom()));
   endtask

   task automatic stop_timer(input logic [2:0] id);
      send_word(OP_STOP, $urandom(), 1'($urandom()), $urandom(), id);
   endtask

   task automatic send_tick();
      send_word(OP_TICK, $urandom(), 1'($urandom()), $urandom(), 3'($urandom()));
   endtask

   task automatic test_expire_and_idle_tick();
      sender_idle_on = 1'b1;
      rx_mode = RX_RANDOM;
      send_tick();
      start_timer(32'd1, 1'b0, 32'h0000_0000);
      start_timer(32'd1, 1'b1, 32'hFFFF_FFFF);
      send_tick();
   endtask

   task automatic test_pool_full();
      rx_mode = RX_PATTERN;
      for (int i = 0; i < NSLOTS; i++)
         start_timer(32'd1, 1'(i), 32'hA5A5_0000 | 32'(i));
      start_timer(32'd5, 1'b1, 32'h1234_5678);
      stop_timer(3'd3);
      stop_timer(3'd3);
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 3'd7);
      start_timer(32'd1, 1'b1, 32'h8000_0001);
      // every slot at one: a single tick empties the whole pool
      send_tick();
   endtask

   task automatic test_zero_delay_wrap();
      rx_mode = RX_RANDOM;
      start_timer(32'd0, 1'b1, 32'h0F0F_0F0F);
      start_timer(32'hFFFF_FFFF, 1'b0, 32'hF0F0_F0F0);
      send_tick();
      send_tick();
      stop_timer(3'd0);
      stop_timer(3'd1);
   endtask

   task automatic test_output_backpressure();
      sender_idle_on = 1'b0;
      rx_mode = RX_FULL;
      rx_hold_req = 300;
      for (int i = 0; i < NSLOTS; i++)
         start_timer($urandom_range(1, 2), 1'($urandom()), $urandom());
      repeat (3) send_tick();
      repeat (3) start_timer($urandom_range(1, 3), 1'($urandom()), $urandom());
      repeat (3) send_tick();
   endtask

   task automatic test_random_traffic();
      int                 pick;
      logic [DELAY_W-1:0] delay;
      sender_idle_on = 1'b1;
      rx_mode = RX_RANDOM;
      for (int n = 0; n < 70; n++) begin
         if (n == 25) rx_mode = RX_PATTERN;
         if (n == 45) begin
            sender_idle_on = 1'b0;
            rx_mode = RX_FULL;
         end
         if (n == 58) begin
            sender_idle_on = 1'b1;
            rx_mode = RX_RANDOM;
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // mostly short delays so timers expire; a few full-width ones
            delay = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 6);
            start_timer(delay, 1'($urandom()), $urandom());
         end else if (pick < 50) begin
            stop_timer(3'($urandom()));
         end else if (pick < 95) begin
            send_tick();
         end else begin
            send_word(OP_UNUSED, $urandom(), 1'($urandom()), $urandom(),
                      3'($urandom()));
         end
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_expire_and_idle_tick();
      test_pool_full();
      test_zero_delay_wrap();
      test_output_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      rx_mode = RX_RANDOM;
      wait_cycles = 0;
      while (pending_reports.size() > 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4 * NSLOTS) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d expected words never arrived", pending_reports.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
